// ----- sv/far_pkg.sv -----
// Package for fraction_arithmetic_reduce: payload structs, opcodes, status codes,
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package far_pkg;

    localparam int OperandWidth = 16;
    localparam int ProdWidth    = 2 * OperandWidth;
    localparam int MagWidth     = ProdWidth + 1;
    localparam int NumWidth     = 33;
    localparam int DenWidth     = 31;
    localparam int CountWidth   = $clog2(MagWidth + 1);

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_EQ  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_DEN_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]                     req_type;
        logic signed [OperandWidth-1:0] a_num;
        logic signed [OperandWidth-1:0] a_den;
        logic signed [OperandWidth-1:0] b_num;
        logic signed [OperandWidth-1:0] b_den;
    } t_in;

    typedef struct packed {
        logic signed [NumWidth-1:0] res_num;
        logic [DenWidth-1:0]        res_den;
        logic                       is_equal;
        logic [1:0]                 status;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic load;     // capture input item
        logic mul;      // form cross products
        logic comb;     // combine into numerator and denominator
        logic gcd_init; // start remainder loop
        logic div_init; // start quotient loop
        logic step;     // one shift-subtract step
        logic gcd_next; // p <- q, q <- remainder
        logic finish;   // build result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic q_zero;   // gcd divisor is zero
        logic step_done;
    } t_sts;

endpackage

// ----- sv/far_datapath.sv -----
// Datapath for fraction_arithmetic_reduce: products, signed combine, Euclid loop
// and the final quotients, the last two on one restoring shift-subtract divider.
// Depends on far_pkg.
module far_datapath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  far_pkg::t_in    i_item,
    input  far_pkg::t_cmd   i_cmd,
    output far_pkg::t_sts   o_sts,
    output far_pkg::t_out   o_res
);

    localparam int W = far_pkg::OperandWidth;
    localparam int P = far_pkg::ProdWidth;
    localparam int M = far_pkg::MagWidth;
    localparam int C = far_pkg::CountWidth;

    far_pkg::t_in r_in;

    // Magnitudes and signs of the operands.
    logic [W-1:0] an_m, ad_m, bn_m, bd_m;
    logic         an_s, ad_s, bn_s, bd_s;
    assign an_s = r_in.a_num[W-1];
    assign ad_s = r_in.a_den[W-1];
    assign bn_s = r_in.b_num[W-1];
    assign bd_s = r_in.b_den[W-1];
    assign an_m = an_s ? W'(-r_in.a_num) : W'(r_in.a_num);
    assign ad_m = ad_s ? W'(-r_in.a_den) : W'(r_in.a_den);
    assign bn_m = bn_s ? W'(-r_in.b_num) : W'(r_in.b_num);
    assign bd_m = bd_s ? W'(-r_in.b_den) : W'(r_in.b_den);

    logic         den_zero, div_zero;
    assign den_zero = (r_in.a_den == '0) || (r_in.b_den == '0);
    assign div_zero = (r_in.req_type == far_pkg::OP_DIV) && (r_in.b_num == '0);

    // Cross products, registered.
    logic [P-1:0] r_x, r_y, r_z;
    logic         r_xs, r_ys, r_zs;
    logic [P-1:0] r_w;
    logic         r_ws;

    // Numerator, denominator of the unreduced result.
    logic [M-1:0] r_n, r_d;
    logic         r_ns, r_ds;

    // Divider state.
    logic [M-1:0] r_p, r_q, r_rem, r_quo, r_g;
    logic [C-1:0] r_cnt;
    logic         r_phase; // 0 numerator quotient, 1 denominator quotient
    logic [M-1:0] r_nq;
    far_pkg::t_out r_res;
    far_pkg::t_out n_res;

    logic [M:0]   trial;
    logic [M-1:0] shifted_rem;
    assign shifted_rem = {r_rem[M-2:0], r_p[M-1]};
    assign trial       = {1'b0, shifted_rem} - {1'b0, r_q};

    logic [M-1:0] sum_mag;
    logic         sum_neg;
    logic         eff_zs;

    // Signed sum of a_num*b_den and (+/-) b_num*a_den.
    always_comb begin
        eff_zs = (r_in.req_type == far_pkg::OP_SUB) ? ~r_zs : r_zs;
        if (r_z == '0) eff_zs = 1'b0;
        if (r_xs == eff_zs) begin
            sum_mag = M'(r_x) + M'(r_z);
            sum_neg = r_xs;
        end else if (r_x >= r_z) begin
            sum_mag = M'(r_x - r_z);
            sum_neg = r_xs;
        end else begin
            sum_mag = M'(r_z - r_x);
            sum_neg = eff_zs;
        end
        if (sum_mag == '0) sum_neg = 1'b0;
    end

    logic [M-1:0] g_eff;
    logic         neg_out;
    logic signed [far_pkg::NumWidth-1:0] num_out;
    assign g_eff   = (r_g == '0) ? M'(1) : r_g;
    assign neg_out = (r_nq != '0) && (r_ns != r_ds);
    assign num_out = neg_out ? far_pkg::NumWidth'(-r_nq) : far_pkg::NumWidth'(r_nq);

    // Datapath registers: load, multiply, combine, divide.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_item;
        end
        if (i_cmd.mul) begin
            r_x  <= an_m * bd_m;  r_xs <= an_s ^ bd_s;
            r_z  <= bn_m * ad_m;  r_zs <= bn_s ^ ad_s;
            r_w  <= ad_m * bd_m;  r_ws <= ad_s ^ bd_s;
            r_y  <= an_m * bn_m;  r_ys <= an_s ^ bn_s;
        end
        if (i_cmd.comb) begin
            unique case (r_in.req_type)
                far_pkg::OP_MUL: begin
                    r_n <= M'(r_y); r_ns <= r_ys;
                    r_d <= M'(r_w); r_ds <= r_ws;
                end
                far_pkg::OP_DIV: begin
                    if (div_zero) begin
                        r_n <= M'(an_m); r_ns <= an_s;
                        r_d <= M'(ad_m); r_ds <= ad_s;
                    end else begin
                        r_n <= M'(r_x); r_ns <= r_xs;
                        r_d <= M'(r_z); r_ds <= r_zs;
                    end
                end
                default: begin
                    r_n <= sum_mag; r_ns <= sum_neg;
                    r_d <= M'(r_w); r_ds <= r_ws;
                end
            endcase
        end
        if (i_cmd.gcd_init) begin
            r_p   <= r_n;
            r_q   <= r_d;
            r_g   <= r_n;
            r_rem <= '0;
            r_cnt <= '0;
            r_phase <= 1'b0;
        end
        if (i_cmd.div_init) begin
            r_p   <= r_phase ? r_d : r_n;
            r_q   <= g_eff;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.step) begin
            if (!trial[M]) begin
                r_rem <= trial[M-1:0];
                r_p   <= {r_p[M-2:0], 1'b1};
            end else begin
                r_rem <= shifted_rem;
                r_p   <= {r_p[M-2:0], 1'b0};
            end
            r_cnt <= r_cnt + C'(1);
        end
        if (i_cmd.gcd_next) begin
            // Gcd pass: g <- q, p <- q, q <- remainder.
            r_g   <= r_q;
            r_p   <= r_q;
            r_q   <= r_rem;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.finish) begin
            if (!r_phase) begin
                r_nq    <= r_p;
                r_phase <= 1'b1;
            end
        end
    end

    // Build the result from status, compare and quotients.
    always_comb begin
        n_res = '0;
        if (den_zero) begin
            n_res.status = far_pkg::ST_DEN_ZERO;
        end else if (r_in.req_type == far_pkg::OP_EQ) begin
            n_res.is_equal = (r_x == r_z) && ((r_x == '0) || (r_xs == r_zs));
        end else if (r_in.req_type <= far_pkg::OP_DIV) begin
            n_res.res_num = num_out;
            n_res.res_den = far_pkg::DenWidth'(r_p);
            n_res.status  = div_zero ? far_pkg::ST_DIV_ZERO : far_pkg::ST_OK;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (i_cmd.finish && r_phase) begin
            r_res <= n_res;
        end
    end

    assign o_sts.q_zero    = (r_q == '0);
    assign o_sts.step_done = (r_cnt == C'(M));
    assign o_res           = r_res;

endmodule

// ----- sv/far_ctrl.sv -----
// Controller for fraction_arithmetic_reduce: sequences load, multiply, combine,
// the Euclid loop and two quotient passes, and runs the output handshake.
// Depends on far_pkg.
module far_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  far_pkg::t_sts i_sts,
    output far_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_COMB, S_GCD, S_GSTEP, S_QSTEP, S_FIN, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_pass, n_pass; // second quotient pass

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_pass  = r_pass;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !(r_valid && i_out_stall)) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_COMB;
            end
            S_COMB: begin
                o_cmd.comb = 1'b1;
                n_state    = S_GCD;
            end
            S_GCD: begin
                o_cmd.gcd_init = 1'b1;
                n_pass         = 1'b0;
                n_state        = S_GSTEP;
            end
            S_GSTEP: begin
                // Remainder loop: p mod q, then shift roles.
                if (i_sts.q_zero) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_QSTEP;
                end else if (i_sts.step_done) begin
                    o_cmd.gcd_next = 1'b1;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_QSTEP: begin
                if (i_sts.step_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_FIN: begin
                if (!r_pass) begin
                    o_cmd.div_init = 1'b1;
                    n_pass         = 1'b1;
                    n_state        = S_QSTEP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_valid && !i_out_stall && r_state != S_OUT) n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pass  <= n_pass;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE) || (r_valid && i_out_stall);
    assign o_out_valid = r_valid;

endmodule

// ----- sv/fraction_arithmetic_reduce.sv -----
// Top level of fraction_arithmetic_reduce: rational add, subtract, multiply,
// divide and equality compare with gcd reduction.
// Depends on far_pkg, far_ctrl, far_datapath.
//
// Usage:
//   Input channel i_in_valid / o_in_stall carries i_in (req_type and two
//   fractions). Output channel o_out_valid / i_out_stall carries o_out
//   (res_num, res_den, is_equal, status). A transfer happens when valid is
//   high and stall is low.
//   One item is in work at a time. After a transfer in, the block forms the
//   cross products, combines them, runs Euclid's algorithm with a 33-step
//   shift-subtract divider and one swap per remainder, then two quotient
//   passes on the same divider. The next item can be taken at the earliest
//   in the cycle that output valid rises, unless the receiver stalls.
//   The result register holds while the receiver stalls; a new item is
//   taken only once the previous result can leave.
//   Synchronous active-low reset clears the controller and the output valid.
module fraction_arithmetic_reduce (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  far_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output far_pkg::t_out o_out
);

    far_pkg::t_cmd cmd;
    far_pkg::t_sts sts;

    far_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    far_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_out)
    );

endmodule

// ----- test/fraction_arithmetic_reduce_tb.sv -----
// Testbench for fraction_arithmetic_reduce: directed table plus random fractions,
// each result checked against an exact rational predictor kept in the bench.
// Depends on far_pkg and the fraction_arithmetic_reduce RTL.
module fraction_arithmetic_reduce_tb;

    localparam int RandomItems = 950;
    localparam int IdleLimit   = 20000;

    typedef struct {
        far_pkg::t_in  stim;
        logic          check_typed;
        far_pkg::t_out typed;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_stall;
    far_pkg::t_in  i_in;
    logic          o_out_valid;
    logic          i_out_stall;
    far_pkg::t_out o_out;

    far_pkg::t_out expected_q[$];
    t_row          rows[$];
    int            mismatches = 0;
    int            table_errors;
    int            idle_cycles;
    bit            timed_out = 1'b0;

    fraction_arithmetic_reduce dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint unsigned euclid(longint unsigned p, longint unsigned q);
        longint unsigned t;
        while (q != 0) begin
            t = p % q;
            p = q;
            q = t;
        end
        return p;
    endfunction

    // Reduce n/d with exact signed 64-bit values; the sign goes to the numerator.
    function automatic far_pkg::t_out reduce_fraction(longint n, longint d);
        far_pkg::t_out r;
        longint unsigned nm;
        longint unsigned dm;
        longint unsigned g;
        logic neg;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        g = euclid(nm, dm);
        if (g == 0) g = 1;
        nm = nm / g;
        dm = dm / g;
        neg = (nm != 0) && ((n < 0) != (d < 0));
        r = '0;
        r.res_num = far_pkg::NumWidth'(neg ? -longint'(nm) : longint'(nm));
        r.res_den = dm[far_pkg::DenWidth-1:0];
        return r;
    endfunction

    function automatic far_pkg::t_out rational_result(far_pkg::t_in x);
        far_pkg::t_out r;
        longint an;
        longint ad;
        longint bn;
        longint bd;
        an = x.a_num;
        ad = x.a_den;
        bn = x.b_num;
        bd = x.b_den;
        r = '0;
        if (ad == 0 || bd == 0) begin
            r.status = far_pkg::ST_DEN_ZERO;
            return r;
        end
        case (x.req_type)
            far_pkg::OP_ADD: r = reduce_fraction(an * bd + bn * ad, ad * bd);
            far_pkg::OP_SUB: r = reduce_fraction(an * bd - bn * ad, ad * bd);
            far_pkg::OP_MUL: r = reduce_fraction(an * bn, ad * bd);
            far_pkg::OP_DIV: begin
                if (bn == 0) begin
                    r = reduce_fraction(an, ad);
                    r.status = far_pkg::ST_DIV_ZERO;
                end else begin
                    r = reduce_fraction(an * bd, ad * bn);
                end
            end
            far_pkg::OP_EQ: r.is_equal = (an * bd == bn * ad);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic far_pkg::t_in make_item(logic [2:0] op, int an, int ad, int bn,
                                               int bd);
        far_pkg::t_in x;
        x.req_type = op;
        x.a_num = an[15:0];
        x.a_den = ad[15:0];
        x.b_num = bn[15:0];
        x.b_den = bd[15:0];
        return x;
    endfunction

    task automatic add_row(far_pkg::t_in x, logic typed_ok, far_pkg::t_out typed_val);
        t_row r;
        r.stim = x;
        r.check_typed = typed_ok;
        r.typed = typed_val;
        rows.push_back(r);
    endtask

    // Random operand: half small values so reductions happen, the rest full range or near the extremes.
    function automatic int rand_field();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return int'($urandom_range(0, 24)) - 12;
            2: return ($urandom_range(0, 1) ? 32767 : -32768)
                      + int'($urandom_range(0, 2)) * ($urandom_range(0, 1) ? 1 : -1);
            default: return int'($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    // Drive one transfer in, with a burst/gap pattern on valid.
    task automatic send_item(far_pkg::t_in x, int gap);
        i_in_valid <= 1'b1;
        i_in <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_q.push_back(rational_result(x));
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Check each transfer out against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out);
            end else begin
                far_pkg::t_out e;
                e = expected_q.pop_front();
                if (o_out.res_num !== e.res_num || o_out.res_den !== e.res_den
                    || o_out.is_equal !== e.is_equal || o_out.status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, o_out);
                end
            end
        end
    end

    // Stall the receiver on its own pattern: phases of none, light and heavy.
    always @(negedge i_clk) begin
        int mode;
        mode = int'(($time / 20000) % 3);
        if (mode == 0) i_out_stall <= 1'b0;
        else if (mode == 1) i_out_stall <= ($urandom_range(0, 3) == 0);
        else i_out_stall <= ($urandom_range(0, 1) == 0);
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (i_rst_n && idle_cycles > IdleLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        far_pkg::t_out z;
        int burst;
        int gap;
        far_pkg::t_in x;
        int drain;
        table_errors = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;

        z = '0;
        z.status = far_pkg::ST_DEN_ZERO;
        add_row(make_item(far_pkg::OP_ADD, 5, 0, 1, 2), 1'b1, z);
        add_row(make_item(far_pkg::OP_EQ, 1, 3, 1, 0), 1'b1, z);
        add_row(make_item(3'd7, 1, 1, 1, 1), 1'b0, z);
        z = '0;
        add_row(make_item(3'd5, 7, 3, 2, 9), 1'b1, z);
        add_row(make_item(3'd6, -1, -1, -1, -1), 1'b1, z);
        z.res_num = 1;
        z.res_den = 1;
        add_row(make_item(far_pkg::OP_ADD, 1, 2, 1, 2), 1'b1, z);
        z.res_num = 0;
        add_row(make_item(far_pkg::OP_SUB, 3, 7, 3, 7), 1'b1, z);
        add_row(make_item(far_pkg::OP_MUL, -32768, -32768, -32768, -32768), 1'b0, z);
        add_row(make_item(far_pkg::OP_ADD, 32767, -32768, 32767, -32768), 1'b0, z);
        add_row(make_item(far_pkg::OP_SUB, -32768, 1, 32767, -1), 1'b0, z);
        add_row(make_item(far_pkg::OP_MUL, 32767, 1, 32767, 1), 1'b0, z);
        add_row(make_item(far_pkg::OP_DIV, -32768, 1, 1, 32767), 1'b0, z);
        add_row(make_item(far_pkg::OP_DIV, 6, -4, 0, 5), 1'b0, z);
        add_row(make_item(far_pkg::OP_DIV, -32768, -32768, 0, -1), 1'b0, z);
        add_row(make_item(far_pkg::OP_DIV, 1, 2, -3, 4), 1'b0, z);
        z = '0;
        z.is_equal = 1'b1;
        add_row(make_item(far_pkg::OP_EQ, 2, 4, -1, -2), 1'b1, z);
        z.is_equal = 1'b0;
        add_row(make_item(far_pkg::OP_EQ, 1, 3, 1, -3), 1'b1, z);
        add_row(make_item(far_pkg::OP_EQ, 0, 5, 0, -7), 1'b0, z);
        add_row(make_item(far_pkg::OP_MUL, 0, -9, 4, 3), 1'b0, z);
        add_row(make_item(far_pkg::OP_ADD, -1, 32767, 1, -32768), 1'b0, z);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table; typed-in results are cross-checked with the predictor.
        foreach (rows[k]) begin
            if (rows[k].check_typed && rational_result(rows[k].stim) !== rows[k].typed) begin
                table_errors++;
                $display("table row %0d disagrees with prediction", k);
            end
            send_item(rows[k].stim, $urandom_range(0, 2));
        end

        // Random fractions in bursts with gaps; pause once to drain fully.
        burst = 0;
        for (int n = 0; n < RandomItems; n++) begin
            x = make_item($urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7))
                          : 3'($urandom_range(0, 4)),
                          rand_field(), rand_field(), rand_field(), rand_field());
            if ($urandom_range(0, 30) == 0) x.a_den = '0;
            if ($urandom_range(0, 30) == 0) x.b_den = '0;
            if (x.req_type == far_pkg::OP_DIV && $urandom_range(0, 6) == 0) x.b_num = '0;
            if (burst == 0) begin
                burst = $urandom_range(1, 12);
                gap = $urandom_range(0, 1) ? $urandom_range(1, 60) : 0;
            end else begin
                gap = 0;
            end
            burst--;
            send_item(x, burst == 0 ? gap : 0);
            if (n == RandomItems / 2) begin
                i_in_valid <= 1'b0;
                while (expected_q.size() != 0) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        while (expected_q.size() != 0) @(negedge i_clk);
        drain = 0;
        while (drain < 2000) begin
            @(negedge i_clk);
            drain++;
        end
        if (mismatches == 0 && table_errors == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/far_pkg.sv
sv/far_datapath.sv
sv/far_ctrl.sv
sv/fraction_arithmetic_reduce.sv
test/fraction_arithmetic_reduce_tb.sv
